FILE: design/nearest_neighbor_route_builder_assert.svh
// assertion macros used by the route builder datapath
`ifndef NEAREST_NEIGHBOR_ROUTE_BUILDER_ASSERT_SVH
`define NEAREST_NEIGHBOR_ROUTE_BUILDER_ASSERT_SVH

// same-cycle implication
`define NNRB_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NNRB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/nnrb_pkg.sv
`timescale 1ns / 1ps

package nnrb_pkg;

  localparam int NODE_W     = 5;
  localparam int VEH_W      = 3;
  localparam int DIST_W     = 16;
  localparam int NVEH_CFG_W = 4;
  localparam int NNOD_CFG_W = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VEHICLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES    = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  localparam logic [NVEH_CFG_W-1:0] NUM_VEHICLES_RST = 4'd2;
  localparam logic [NNOD_CFG_W-1:0] NUM_NODES_RST    = 5'd31;

  // datapath strobes from one control word
  typedef struct packed {
    logic acc_in;
    logic start_en;
    logic rd_en;
    logic cmp_en;
    logic emit_en;
  } ctl_t;

  // flags the sequencer branches on
  typedef struct packed {
    logic run_go;
    logic scan_more;
    logic out_busy;
    logic done;
  } status_t;

endpackage

FILE: design/nnrb_useq.sv
`timescale 1ns / 1ps

module nnrb_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  nnrb_pkg::status_t status,
  output nnrb_pkg::ctl_t   ctl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_CMP,
    ST_EMIT,
    ST_FIN
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_RUN_GO,
    COND_MORE,
    COND_OUT_BUSY,
    COND_DONE
  } cond_t;

  typedef struct packed {
    nnrb_pkg::ctl_t ctl;
    cond_t          cond;
    step_t          jmp;
    step_t          nxt;
  } uword_t;

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   take;

  // control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{ctl: '0, cond: COND_ALWAYS, jmp: ST_IDLE, nxt: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.ctl.acc_in = 1'b1;
        w.cond       = COND_RUN_GO;
        w.jmp        = ST_START;
        w.nxt        = ST_IDLE;
      end
      ST_START: begin
        w.ctl.start_en = 1'b1;
        w.jmp          = ST_RD;
      end
      ST_RD: begin
        w.ctl.rd_en = 1'b1;
        w.jmp       = ST_CMP;
      end
      ST_CMP: begin
        w.ctl.cmp_en = 1'b1;
        w.cond       = COND_MORE;
        w.jmp        = ST_RD;
        w.nxt        = ST_EMIT;
      end
      ST_EMIT: begin
        w.ctl.emit_en = 1'b1;
        w.cond        = COND_OUT_BUSY;
        w.jmp         = ST_EMIT;
        w.nxt         = ST_FIN;
      end
      ST_FIN: begin
        w.cond = COND_DONE;
        w.jmp  = ST_IDLE;
        w.nxt  = ST_START;
      end
      default: begin
        w.jmp = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    uw = ucode(step_r);
    case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_RUN_GO:   take = status.run_go;
      COND_MORE:     take = status.scan_more;
      COND_OUT_BUSY: take = status.out_busy;
      COND_DONE:     take = status.done;
      default:       take = 1'b1;
    endcase
    step_nxt = take ? uw.jmp : uw.nxt;
    ctl      = uw.ctl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: design/nnrb_datapath.sv
`timescale 1ns / 1ps
`include "nearest_neighbor_route_builder_assert.svh"

module nnrb_datapath #(
  parameter int MAX_NODES    = 31,
  parameter int MAX_VEHICLES = 8,
  parameter int DIST_BITS    = 16,
  localparam int NW  = $clog2(MAX_NODES + 1),
  localparam int VW  = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1,
  localparam int VCW = $clog2(MAX_VEHICLES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nnrb_pkg::ctl_t                ctl,
  output nnrb_pkg::status_t             status,
  input  logic [NW-1:0]                 n_sat,
  input  logic [VCW-1:0]                nv_sat,
  input  logic                          in_tvalid,
  input  logic                          in_cmd,
  input  logic [nnrb_pkg::NODE_W-1:0]   in_from_node,
  input  logic [nnrb_pkg::NODE_W-1:0]   in_to_node,
  input  logic [nnrb_pkg::DIST_W-1:0]   in_distance,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [nnrb_pkg::VEH_W-1:0]    out_vehicle,
  output logic [nnrb_pkg::NODE_W-1:0]   out_node,
  output logic                          out_tlast
);

  logic [DIST_BITS-1:0] mem_r [1 << (2 * NW)];
  logic [DIST_BITS-1:0] rd_data_r;

  logic [MAX_NODES:1] visited_r;
  logic [NW-1:0]      last_node_r [MAX_VEHICLES];
  logic [VW-1:0]      cv_r;
  logic [VW-1:0]      cv_nxt;
  logic [NW-1:0]      left_r;
  logic [NW-1:0]      from_r;
  logic [NW-1:0]      j_r;
  logic [NW-1:0]      best_r;
  logic [DIST_BITS-1:0] best_dist_r;
  logic               found_r;

  logic                        out_valid_r;
  logic [nnrb_pkg::VEH_W-1:0]  out_vehicle_r;
  logic [nnrb_pkg::NODE_W-1:0] out_node_r;
  logic                        out_tlast_r;

  logic in_fire;
  logic load_ok;
  logic run_fire;
  logic out_busy;
  logic emit_fire;
  logic take_j;

  assign in_fire  = in_tvalid && ctl.acc_in && rst_n;
  assign load_ok  = in_fire && (in_cmd == nnrb_pkg::CMD_LOAD)
                    && (32'(in_from_node) <= MAX_NODES) && (32'(in_to_node) <= MAX_NODES);
  assign run_fire = in_fire && (in_cmd == nnrb_pkg::CMD_RUN);
  assign out_busy = out_valid_r && !out_tready;
  assign emit_fire = ctl.emit_en && !out_busy;
  assign take_j   = !visited_r[j_r] && (!found_r || (rd_data_r < best_dist_r));
  assign cv_nxt   = ((32'(cv_r) + 1) >= 32'(nv_sat)) ? '0 : cv_r + VW'(1);

  assign status.run_go    = run_fire && (n_sat != '0);
  assign status.scan_more = j_r < n_sat;
  assign status.out_busy  = out_busy;
  assign status.done      = left_r == '0;

  // distance store
  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem_r[{NW'(in_from_node), NW'(in_to_node)}] <= DIST_BITS'(32'(in_distance));
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[{from_r, j_r}];
    end
  end

  // route state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      for (int v = 0; v < MAX_VEHICLES; v++) begin
        last_node_r[v] <= '0;
      end
      cv_r   <= '0;
      left_r <= '0;
    end else if (run_fire) begin
      visited_r <= '0;
      for (int v = 0; v < MAX_VEHICLES; v++) begin
        last_node_r[v] <= '0;
      end
      cv_r   <= '0;
      left_r <= n_sat;
    end else if (emit_fire) begin
      if (found_r) begin
        visited_r[best_r]  <= 1'b1;
        last_node_r[cv_r]  <= best_r;
        left_r             <= left_r - NW'(1);
      end else begin
        left_r <= '0;
      end
      cv_r <= cv_nxt;
    end
  end

  // nearest search
  always_ff @(posedge clk) begin
    if (ctl.start_en) begin
      from_r  <= last_node_r[cv_r];
      j_r     <= NW'(1);
      found_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      if (take_j) begin
        found_r     <= 1'b1;
        best_dist_r <= rd_data_r;
        best_r      <= j_r;
      end
      j_r <= j_r + NW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire && found_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire && found_r) begin
      out_vehicle_r <= nnrb_pkg::VEH_W'(32'(cv_r));
      out_node_r    <= nnrb_pkg::NODE_W'(32'(best_r));
      out_tlast_r   <= left_r == NW'(1);
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_vehicle = out_vehicle_r;
  assign out_node    = out_node_r;
  assign out_tlast   = out_tlast_r;

  `NNRB_ASSERT_NOW(a_node_range, clk, rst_n, out_valid_r,
    (out_node_r != '0) && (32'(out_node_r) <= MAX_NODES), "customer node out of range")
  `NNRB_ASSERT_NOW(a_scan_range, clk, rst_n, ctl.cmp_en,
    (j_r != '0) && (j_r <= n_sat), "scan index outside customer range")
  `NNRB_ASSERT_NOW(a_emit_fresh, clk, rst_n, emit_fire && found_r,
    !visited_r[best_r], "customer assigned twice")
  `NNRB_ASSERT_NEXT(a_last_done, clk, rst_n, emit_fire && found_r && (left_r == NW'(1)),
    out_tlast_r && (left_r == '0), "final assignment not flagged")

endmodule

FILE: design/nearest_neighbor_route_builder.sv
`timescale 1ns / 1ps
// Greedy nearest-neighbor route builder for several vehicles. A load transfer
// (tuser = 0) writes one distance dist(from,to); loads stream at one per cycle
// while idle. A run transfer (tuser = 1) resets the visited marks
// and puts all vehicles at the depot, then emits one vehicle/node transfer per
// customer, tlast on the final one. For each assignment the microprogram reads
// one distance per entry through the single read port of the distance store
// (read step, compare step), plus start, emit and branch steps, and the emit
// step waits on any output stall. No input is taken during a run. Entries never
// loaded read as unknown. Configuration must be written only while idle; the
// block itself does not enforce this.

module nearest_neighbor_route_builder #(
  parameter int MAX_NODES    = 31,
  parameter int MAX_VEHICLES = 8,
  parameter int DIST_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [nnrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nnrb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // from_node [4:0], to_node [9:5], distance [25:10], zero [31:26]
  input  logic [nnrb_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd [0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // vehicle [2:0], node [7:3]
  output logic [nnrb_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);

  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int VCW = $clog2(MAX_VEHICLES + 1);

  logic [nnrb_pkg::NVEH_CFG_W-1:0] num_vehicles_r;
  logic [nnrb_pkg::NNOD_CFG_W-1:0] num_nodes_r;
  logic [NW-1:0]                   n_sat;
  logic [VCW-1:0]                  nv_sat;

  nnrb_pkg::ctl_t    ctl;
  nnrb_pkg::status_t status;

  logic [nnrb_pkg::VEH_W-1:0]  out_vehicle;
  logic [nnrb_pkg::NODE_W-1:0] out_node;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vehicles_r <= nnrb_pkg::NUM_VEHICLES_RST;
      num_nodes_r    <= nnrb_pkg::NUM_NODES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nnrb_pkg::CFG_NUM_VEHICLES: num_vehicles_r <= nnrb_pkg::NVEH_CFG_W'(cfg_wdata);
        nnrb_pkg::CFG_NUM_NODES:    num_nodes_r    <= nnrb_pkg::NNOD_CFG_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // clamp configuration to the built sizes
  always_comb begin
    if (32'(num_nodes_r) > MAX_NODES) begin
      n_sat = NW'(MAX_NODES);
    end else begin
      n_sat = NW'(num_nodes_r);
    end
    if (num_vehicles_r == '0) begin
      nv_sat = VCW'(1);
    end else if (32'(num_vehicles_r) > MAX_VEHICLES) begin
      nv_sat = VCW'(MAX_VEHICLES);
    end else begin
      nv_sat = VCW'(num_vehicles_r);
    end
  end

  nnrb_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  nnrb_datapath #(
    .MAX_NODES    (MAX_NODES),
    .MAX_VEHICLES (MAX_VEHICLES),
    .DIST_BITS    (DIST_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .status       (status),
    .n_sat        (n_sat),
    .nv_sat       (nv_sat),
    .in_tvalid    (in_tvalid),
    .in_cmd       (in_tuser),
    .in_from_node (in_tdata[4:0]),
    .in_to_node   (in_tdata[9:5]),
    .in_distance  (in_tdata[25:10]),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_vehicle  (out_vehicle),
    .out_node     (out_node),
    .out_tlast    (out_tlast)
  );

  assign in_tready = ctl.acc_in && rst_n;
  assign out_tdata = {out_node, out_vehicle};

endmodule
